FILE: hdl/dgls_pkg.sv
// types and constants shared by the depth-to-gray-level shader
// no dependencies
`default_nettype none
package dgls_pkg;
    localparam int RAYS_PER_PIXEL = 9;
    localparam int DIST_W = 32;
    localparam int QUOT_W = 17;
    localparam int SUM_W = 20;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [SUM_W-1:0] HALF_Q16 = 20'h08000;
    localparam logic signed [DIST_W-1:0] NEAR_RESET = 32'sh7FFFFFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [1:0] CFG_FALLOFF_MIN = 2'd0;
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

    typedef struct packed {
        logic                     operation;
        logic signed [DIST_W-1:0] distance;
    } t_in_item;

    typedef struct packed {
        logic [7:0] level;
        logic       last_pixel;
    } t_out_item;
endpackage
`default_nettype wire

FILE: hdl/dgls_ray_mem.sv
// ray distance store: one write port, one registered read port
// depends on dgls_pkg
`default_nettype none
module dgls_ray_mem #(
    parameter int DEPTH = 9216,
    parameter int ADDR_W = 14
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [ADDR_W-1:0]           i_waddr,
    input  wire [dgls_pkg::DIST_W-1:0] i_wdata,
    input  wire [ADDR_W-1:0]           i_raddr,
    output logic [dgls_pkg::DIST_W-1:0] o_rdata
);
    import dgls_pkg::*;

    logic [DIST_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/dgls_div.sv
// bit-serial restoring divider: quotient of (num << 16) / den, num <= den
// depends on dgls_pkg
`default_nettype none
module dgls_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [dgls_pkg::DIST_W-1:0] i_num,
    input  wire [dgls_pkg::DIST_W-1:0] i_den,
    output logic                       o_done,
    output logic [dgls_pkg::QUOT_W-1:0] o_quot
);
    import dgls_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [DIST_W:0]   r_rem;
    logic [DIST_W-1:0] r_den;
    logic [DIST_W:0]   n_trial;
    logic              n_ge;

    // first step compares num itself, later steps the doubled remainder
    always_comb begin
        n_trial = (r_cnt == 5'd0) ? r_rem : {r_rem[DIST_W-1:0], 1'b0};
        n_ge = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == 5'(QUOT_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            o_quot <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
            o_quot <= {o_quot[QUOT_W-2:0], n_ge};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/depth_to_gray_level_shader_unit.sv
// depth-to-gray-level shader top level: frame control, shading sequencer
// depends on dgls_pkg, dgls_ray_mem, dgls_div
// a load is taken while idle; an emit walks nine rays: an unloaded ray goes read then accumulate,
// a miss or flat-range hit goes read, check, accumulate, a hit also waits on the 17-step divider,
// then comes the result strobe; emits past the last pixel finish with no result
// synchronous reset restores register defaults; the ray memory is not cleared
`default_nettype none
module depth_to_gray_level_shader_unit #(
    parameter int MAX_PIXELS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  dgls_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output dgls_pkg::t_out_item  o_result,
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_idx,
    input  wire [16:0]           i_cfg_data
);
    import dgls_pkg::*;

    localparam int RAYS_MAX = RAYS_PER_PIXEL * MAX_PIXELS;
    localparam int ADDR_W = $clog2(RAYS_MAX);
    localparam int CNT_W = $clog2(RAYS_MAX + 1);
    localparam int PIX_W = $clog2(MAX_PIXELS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [16:0] r_falloff_min;
    logic [8:0]  r_level_count;
    logic [10:0] r_pixel_count;

    logic [2:0]               r_state;
    logic signed [DIST_W-1:0] r_near;
    logic signed [DIST_W-1:0] r_far;
    logic [CNT_W-1:0]         r_loaded;
    logic [PIX_W-1:0]         r_ptr;
    logic                     r_emitting;
    logic [ADDR_W-1:0]        r_addr;
    logic [3:0]               r_k;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_div_start;
    logic [DIST_W-1:0]        r_num;
    logic [DIST_W-1:0]        r_den;
    logic [16:0]              r_scale;

    logic [PIX_W-1:0]         n_pixels;
    logic [CNT_W-1:0]         n_limit;
    logic [CNT_W-1:0]         n_loaded_eff;
    logic signed [DIST_W-1:0] n_near_eff;
    logic signed [DIST_W-1:0] n_far_eff;
    logic                     n_load;
    logic                     n_we;
    logic [DIST_W-1:0]        n_rdata;
    logic signed [DIST_W-1:0] n_d;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [16:0]              n_floor;
    logic [16:0]              n_raw_scale;
    logic [4:0]               n_level_full;
    logic [7:0]               n_top;

    always_comb begin
        if (r_pixel_count == 11'd0) begin
            n_pixels = PIX_W'(1);
        end else if (32'(r_pixel_count) > 32'(MAX_PIXELS)) begin
            n_pixels = PIX_W'(MAX_PIXELS);
        end else begin
            n_pixels = PIX_W'(r_pixel_count);
        end
        n_limit = CNT_W'(32'(n_pixels) * 32'(RAYS_PER_PIXEL));
        // a load after emission begins a new frame
        n_loaded_eff = r_emitting ? '0 : r_loaded;
        n_near_eff = r_emitting ? NEAR_RESET : r_near;
        n_far_eff = r_emitting ? '0 : r_far;
        n_load = start && !busy && (i_item.operation == OP_LOAD);
        n_we = n_load && (n_loaded_eff < n_limit);
        n_d = $signed(n_rdata);
        n_floor = (r_falloff_min > ONE_Q16) ? ONE_Q16 : r_falloff_min;
        n_raw_scale = (div_quot >= ONE_Q16) ? 17'd0 : (ONE_Q16 - div_quot);
        n_level_full = 5'((r_sum + HALF_Q16) >> 16);
        if (r_level_count == 9'd0) begin
            n_top = 8'd0;
        end else if (r_level_count > 9'd256) begin
            n_top = 8'd255;
        end else begin
            n_top = 8'(r_level_count - 9'd1);
        end
    end

    assign busy = (r_state != S_IDLE);

    dgls_ray_mem #(
        .DEPTH(RAYS_MAX),
        .ADDR_W(ADDR_W)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(n_we),
        .i_waddr(ADDR_W'(n_loaded_eff)),
        .i_wdata(i_item.distance),
        .i_raddr(r_addr),
        .o_rdata(n_rdata)
    );

    dgls_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num(r_num),
        .i_den(r_den),
        .o_done(div_done),
        .o_quot(div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falloff_min <= '0;
            r_level_count <= 9'd10;
            r_pixel_count <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FALLOFF_MIN: r_falloff_min <= i_cfg_data;
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[8:0];
                CFG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_near <= NEAR_RESET;
            r_far <= '0;
            r_loaded <= '0;
            r_ptr <= '0;
            r_emitting <= 1'b0;
            r_div_start <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_CHK) && (n_d > 0) && (r_far > r_near);
            o_done <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (n_load) begin
                        r_emitting <= 1'b0;
                        if (r_emitting) begin
                            r_ptr <= '0;
                        end
                        if (n_we) begin
                            r_loaded <= n_loaded_eff + CNT_W'(1);
                            if (i_item.distance > 0 && i_item.distance < n_near_eff) begin
                                r_near <= i_item.distance;
                            end else begin
                                r_near <= n_near_eff;
                            end
                            if (i_item.distance > n_far_eff) begin
                                r_far <= i_item.distance;
                            end else begin
                                r_far <= n_far_eff;
                            end
                        end else if (r_emitting) begin
                            r_loaded <= '0;
                            r_near <= NEAR_RESET;
                            r_far <= '0;
                        end
                    end else if (start) begin
                        r_emitting <= 1'b1;
                        if (r_ptr < n_pixels) begin
                            r_addr <= ADDR_W'(32'(r_ptr) * 32'(RAYS_PER_PIXEL));
                            r_k <= '0;
                            r_sum <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // rays never loaded count as misses
                    if (CNT_W'(r_addr) < r_loaded) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_ACC;
                        r_scale <= '0;
                    end
                end
                S_CHK: begin
                    if (n_d > 0) begin
                        if (r_far <= r_near) begin
                            r_scale <= ONE_Q16;
                            r_state <= S_ACC;
                        end else begin
                            r_num <= (n_d > r_near) ? DIST_W'(n_d - r_near) : '0;
                            r_den <= DIST_W'(r_far - r_near);
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_scale <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_scale <= (n_raw_scale < n_floor) ? n_floor : n_raw_scale;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum <= r_sum + SUM_W'(r_scale);
                    if (r_k == 4'(RAYS_PER_PIXEL - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + 4'd1;
                        r_addr <= r_addr + ADDR_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    r_ptr <= r_ptr + PIX_W'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // misses take scale zero, which the floor does not apply to
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_result.level <= (8'(n_level_full) > n_top) ? n_top : 8'(n_level_full);
            o_result.last_pixel <= (r_ptr + PIX_W'(1)) == n_pixels;
        end
    end

    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_OUT)
        else $error("result strobe without a finished pixel");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loaded) <= RAYS_MAX)
        else $error("ray count beyond store depth");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");
endmodule
`default_nettype wire
